### rtl/slx_pkg.sv
// ----------------------------------------------------------------------------
// slx_pkg - shared types and constants of the frame receiver
// Item and result layouts, event and operation codes, queue sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package slx_pkg;

  // default store size for the payload buffer
  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  // most payload results that one take streams out
  localparam int unsigned RESULT_LIMIT    = 32;
  // reset value of the start-of-frame register
  localparam logic [7:0]  START_BYTE_RST  = 8'hAA;

  // queue depths (powers of two, pointers wrap by truncation)
  localparam int unsigned IQ_DEPTH  = 2;
  localparam int unsigned OQ_DEPTH  = 4;
  localparam int unsigned IQ_PTR_W  = $clog2(IQ_DEPTH);
  localparam int unsigned OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int unsigned IQ_CNT_W  = $clog2(IQ_DEPTH + 1);
  localparam int unsigned OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_DONE    = 3'd1;
  localparam logic [2:0] EV_BADSUM  = 3'd2;
  localparam logic [2:0] EV_IGNORED = 3'd3;
  localparam logic [2:0] EV_TOOLONG = 3'd4;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_data;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       frame_ready;
    logic [7:0] command;
    logic [5:0] length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

### rtl/slx_front.sv
// ----------------------------------------------------------------------------
// slx_front - input side of the frame receiver
// Takes items from the push/full channel into a short queue for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  output logic               full_o,
  input  wire                operation_i,
  input  wire  [7:0]         rx_data_i,
  output logic               item_vld_o,
  output slx_pkg::item_t     item_o,
  input  wire                item_pop_i
);

  slx_pkg::item_t                        slot_q [slx_pkg::IQ_DEPTH];
  logic [slx_pkg::IQ_PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
  logic [slx_pkg::IQ_CNT_W-1:0]          cnt_q, cnt_d;
  logic                                  wr_en, rd_en;

  assign full_o     = (cnt_q == slx_pkg::IQ_CNT_W'(slx_pkg::IQ_DEPTH));
  assign item_vld_o = (cnt_q != '0);
  assign item_o     = slot_q[rd_ptr_q];
  assign wr_en      = push_i && !full_o;
  assign rd_en      = item_pop_i && item_vld_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // item slots
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q].operation <= operation_i;
      slot_q[wr_ptr_q].rx_data   <= rx_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/slx_back.sv
// ----------------------------------------------------------------------------
// slx_back - parser and take engine of the frame receiver
// Runs the frame state machine, keeps the payload buffer, streams taken frames.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_back #(
  parameter int unsigned MAX_PAYLOAD = slx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [7:0]                     cfg_data_i,
  input  wire                            item_vld_i,
  input  slx_pkg::item_t                 item_i,
  output logic                           item_pop_o,
  input  wire  [slx_pkg::OQ_CNT_W-1:0]   oq_cnt_i,
  output logic                           res_vld_o,
  output slx_pkg::result_t               res_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // parser phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CSUM = 3'd4;
  localparam logic [2:0] PH_HELD = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic [7:0]        start_q;
  logic [7:0]        cmd_q, cmd_d;
  logic [5:0]        len_q, len_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [7:0]        csum_q, csum_d;
  logic [4:0]        k_q, k_d;

  logic [7:0]        mem_q [MAX_PAYLOAD];
  logic [7:0]        rd_q;
  logic [AW-1:0]     rd_addr;
  logic              we;

  logic              stage_vld_q;
  slx_pkg::result_t  stage_q, res_d;

  logic              issue;
  logic [7:0]        b;
  logic [5:0]        n_len;
  logic [5:0]        k_next;
  logic              is_last;

  // credit check: room in the result queue counting the result in flight
  assign issue = item_vld_i &&
                 (({1'b0, oq_cnt_i} + (slx_pkg::OQ_CNT_W + 1)'(stage_vld_q)) <
                  (slx_pkg::OQ_CNT_W + 1)'(slx_pkg::OQ_DEPTH));

  assign b       = item_i.rx_data;
  assign n_len   = (len_q > 6'(slx_pkg::RESULT_LIMIT)) ? 6'(slx_pkg::RESULT_LIMIT) : len_q;
  assign k_next  = {1'b0, k_q} + 6'd1;
  assign is_last = (k_next == n_len);
  assign rd_addr = AW'(k_q);

  // frame state machine and take sequencing
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    csum_d     = csum_q;
    k_d        = k_q;
    we         = 1'b0;
    item_pop_o = 1'b0;
    res_d      = '0;
    res_d.last = 1'b1;
    if (issue) begin
      if (item_i.operation == slx_pkg::OP_BYTE) begin
        item_pop_o = 1'b1;
        unique case (phase_q)
          PH_CMD: begin
            cmd_d   = b;
            csum_d  = b;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (b > 8'(MAX_PAYLOAD)) begin
              phase_d         = PH_HUNT;
              res_d.event_res = slx_pkg::EV_TOOLONG;
            end else begin
              len_d   = b[5:0];
              csum_d  = csum_q ^ b;
              cnt_d   = '0;
              phase_d = (b == 8'd0) ? PH_CSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            we     = (cnt_q < 6'(MAX_PAYLOAD));
            csum_d = csum_q ^ b;
            cnt_d  = cnt_q + 6'd1;
            if (cnt_d >= len_q) phase_d = PH_CSUM;
          end
          PH_CSUM: begin
            if (b == csum_q) begin
              phase_d         = PH_HELD;
              res_d.event_res = slx_pkg::EV_DONE;
            end else begin
              phase_d         = PH_HUNT;
              res_d.event_res = slx_pkg::EV_BADSUM;
            end
          end
          PH_HELD: begin
            res_d.event_res = slx_pkg::EV_IGNORED;
          end
          default: begin
            phase_d = (b == start_q) ? PH_CMD : PH_HUNT;
          end
        endcase
      end else if (phase_q != PH_HELD) begin
        // take with nothing held
        item_pop_o = 1'b1;
      end else begin
        res_d.frame_ready = 1'b1;
        res_d.command     = cmd_q;
        res_d.length      = len_q;
        if (n_len == 6'd0) begin
          item_pop_o = 1'b1;
          phase_d    = PH_HUNT;
        end else begin
          res_d.payload_valid = 1'b1;
          res_d.payload_index = k_q;
          res_d.last          = is_last;
          if (is_last) begin
            item_pop_o = 1'b1;
            k_d        = '0;
            phase_d    = PH_HUNT;
          end else begin
            k_d = k_next[4:0];
          end
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      start_q     <= slx_pkg::START_BYTE_RST;
      cmd_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      csum_q      <= '0;
      k_q         <= '0;
      stage_vld_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      csum_q      <= csum_d;
      k_q         <= k_d;
      stage_vld_q <= issue;
      if (cfg_we_i) start_q <= cfg_data_i;
    end
  end

  // payload buffer, registered read lines up with the result stage
  always_ff @(posedge clk_i) begin
    if (we) mem_q[cnt_q[AW-1:0]] <= b;
    rd_q    <= mem_q[rd_addr];
    stage_q <= res_d;
  end

  // result stage output, payload byte merged from the buffer read
  always_comb begin
    res_o = stage_q;
    res_o.payload_byte = stage_q.payload_valid ? rd_q : 8'd0;
  end
  assign res_vld_o = stage_vld_q;

endmodule

`default_nettype wire

### rtl/slx_outq.sv
// ----------------------------------------------------------------------------
// slx_outq - result queue of the frame receiver
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_outq (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            wr_i,
  input  slx_pkg::result_t               wr_data_i,
  input  wire                            pop_i,
  output logic                           empty_o,
  output slx_pkg::result_t               head_o,
  output logic [slx_pkg::OQ_CNT_W-1:0]   cnt_o
);

  slx_pkg::result_t                 slot_q [slx_pkg::OQ_DEPTH];
  logic [slx_pkg::OQ_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [slx_pkg::OQ_CNT_W-1:0]     cnt_q;
  logic                             rd_en;

  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign cnt_o   = cnt_q;
  assign rd_en   = pop_i && !empty_o;

  // pointers and count; the back end never writes into a full queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i)  wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_i && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_i && rd_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // result slots
  always_ff @(posedge clk_i) begin
    if (wr_i) slot_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

### rtl/sof_len_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// sof_len_xor_frame_receiver - start/command/length/payload/XOR frame parser
// Usage:
//   Input channel (push_i/full_o): one item per accepted edge; operation_i 0
//   feeds rx_data_i to the parser, 1 takes the held frame.
//   Result channel (empty_o/pop_i): the oldest result shows while empty_o is
//   low. A byte gives one result; a take gives one result per payload byte
//   (up to 32, last_o on the final one) or a single result if the payload
//   is empty or no frame is held.
//   Config channel (cfg_valid_i/cfg_ready_o): writes the start byte; ready is
//   always high. Write only while the block is idle.
//   Throughput: one result per cycle while the result queue has room, so
//   one byte per cycle, set by the single-issue parser stage; a take of n
//   payload bytes gives n results.
//   Path: an accepted item's result passes the parser stage with registered
//   payload buffer read, then the result queue write, to reach the ports.
//   Reset: queues empty, parser hunting for the start byte, start byte 0xAA.
//   Stall: a 2-entry input queue and a 4-entry result queue let either side
//   stall; when the result queue fills, the parser halts, the input queue
//   fills and full_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sof_len_xor_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = slx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  output logic        full_o,
  input  wire         operation_i,
  input  wire  [7:0]  rx_data_i,
  output logic        empty_o,
  input  wire         pop_i,
  output logic [2:0]  event_res_o,
  output logic        frame_ready_o,
  output logic [7:0]  command_o,
  output logic [5:0]  length_o,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [4:0]  payload_index_o,
  output logic        last_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_start_byte_i
);

  slx_pkg::item_t                    item;
  logic                              item_vld, item_pop;
  logic                              res_vld;
  slx_pkg::result_t                  res, head;
  logic [slx_pkg::OQ_CNT_W-1:0]      oq_cnt;

  assign cfg_ready_o = 1'b1;

  slx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .operation_i (operation_i),
    .rx_data_i   (rx_data_i),
    .item_vld_o  (item_vld),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  slx_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_start_byte_i),
    .item_vld_i (item_vld),
    .item_i     (item),
    .item_pop_o (item_pop),
    .oq_cnt_i   (oq_cnt),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  slx_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_vld),
    .wr_data_i (res),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .head_o    (head),
    .cnt_o     (oq_cnt)
  );

  // result fields
  assign event_res_o     = head.event_res;
  assign frame_ready_o   = head.frame_ready;
  assign command_o       = head.command;
  assign length_o        = head.length;
  assign payload_valid_o = head.payload_valid;
  assign payload_byte_o  = head.payload_byte;
  assign payload_index_o = head.payload_index;
  assign last_o          = head.last;

endmodule

`default_nettype wire

### rtl/slx_checker.sv
// ----------------------------------------------------------------------------
// slx_checker - port-level checks for the frame receiver
// Result field consistency and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        empty_o,
  input wire        pop_i,
  input wire [2:0]  event_res_o,
  input wire        frame_ready_o,
  input wire [7:0]  command_o,
  input wire [5:0]  length_o,
  input wire        payload_valid_o,
  input wire [7:0]  payload_byte_o,
  input wire [4:0]  payload_index_o,
  input wire        last_o
);

  // byte events never carry frame data
  a_event_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && event_res_o != slx_pkg::EV_NONE) |->
      (!frame_ready_o && !payload_valid_o && command_o == 8'd0 && length_o == 6'd0))
    else $error("event result carries frame fields");

  // payload results only come from a held frame
  a_payload_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && payload_valid_o) |-> (frame_ready_o && length_o != 6'd0))
    else $error("payload result without a held frame");

  // idle payload fields read as zero, with last set
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !payload_valid_o) |->
      (payload_byte_o == 8'd0 && payload_index_o == 5'd0 && last_o))
    else $error("non-payload result with payload fields set");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(command_o) && $stable(payload_byte_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind sof_len_xor_frame_receiver slx_checker u_slx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty_o         (empty_o),
  .pop_i           (pop_i),
  .event_res_o     (event_res_o),
  .frame_ready_o   (frame_ready_o),
  .command_o       (command_o),
  .length_o        (length_o),
  .payload_valid_o (payload_valid_o),
  .payload_byte_o  (payload_byte_o),
  .payload_index_o (payload_index_o),
  .last_o          (last_o)
);

`default_nettype wire

### bench/tb_sof_len_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_sof_len_xor_frame_receiver - self-checking bench for the frame receiver
// Feeds framed byte streams and take operations through the push/full queue
// and pops results with an irregular stall pattern. A scoreboard class runs
// its own model of the parser and compares every popped result field by
// field. The start byte is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_sof_len_xor_frame_receiver;

  import slx_pkg::*;

  localparam int unsigned PAYLOAD_CAP   = MAX_PAYLOAD_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT    = 1000;

  // parser phases of the model
  typedef enum logic [2:0] {
    SEEK_SOF, GET_CMD, GET_LEN, GET_DATA, GET_CSUM, FRAME_HELD
  } parse_phase_e;

  // model of the parser plus the queue of results still owed by the block
  class frame_scoreboard;
    result_t      expected_q[$];
    int unsigned  fail_count;
    logic [7:0]   start_byte;
    parse_phase_e phase;
    logic [7:0]   held_cmd;
    logic [5:0]   held_len;
    logic [5:0]   data_count;
    logic [7:0]   xor_sum;
    logic [7:0]   store [PAYLOAD_CAP];

    function new();
      fail_count = 0;
      start_byte = START_BYTE_RST;
      phase      = SEEK_SOF;
      held_cmd   = '0;
      held_len   = '0;
      data_count = '0;
      xor_sum    = '0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_start_byte(logic [7:0] value);
      start_byte = value;
    endfunction

    // advance the model by one accepted item and queue what it yields
    function void note_item(logic op, logic [7:0] data);
      result_t     r;
      int unsigned n;
      r      = '0;
      r.last = 1'b1;
      if (op == OP_BYTE) begin
        case (phase)
          GET_CMD: begin
            held_cmd = data;
            xor_sum  = data;
            phase    = GET_LEN;
          end
          GET_LEN: begin
            if (data > PAYLOAD_CAP) begin
              phase       = SEEK_SOF;
              r.event_res = EV_TOOLONG;
            end else begin
              held_len   = data[5:0];
              xor_sum    = xor_sum ^ data;
              data_count = '0;
              phase      = (data == 8'd0) ? GET_CSUM : GET_DATA;
            end
          end
          GET_DATA: begin
            if (data_count < PAYLOAD_CAP) store[data_count] = data;
            xor_sum    = xor_sum ^ data;
            data_count = data_count + 6'd1;
            if (data_count >= held_len) phase = GET_CSUM;
          end
          GET_CSUM: begin
            if (data == xor_sum) begin
              phase       = FRAME_HELD;
              r.event_res = EV_DONE;
            end else begin
              phase       = SEEK_SOF;
              r.event_res = EV_BADSUM;
            end
          end
          FRAME_HELD: r.event_res = EV_IGNORED;
          default: phase = (data == start_byte) ? GET_CMD : SEEK_SOF;
        endcase
        expected_q.push_back(r);
      end else if (phase != FRAME_HELD) begin
        // take with nothing held: a single blank result
        expected_q.push_back(r);
      end else begin
        n = held_len;
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        if (n > PAYLOAD_CAP) n = PAYLOAD_CAP;
        r.frame_ready = 1'b1;
        r.command     = held_cmd;
        r.length      = held_len;
        if (n == 0) expected_q.push_back(r);
        for (int unsigned k = 0; k < n; k++) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = store[k];
          r.payload_index = 5'(k);
          r.last          = (k + 1 == n);
          expected_q.push_back(r);
        end
        phase = SEEK_SOF;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        fail_count++;
      end
    endfunction

    // compare one popped result with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result popped with nothing owed (event_res %0d)", got.event_res);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("event_res", 8'(want.event_res), 8'(got.event_res));
      compare_field("frame_ready", 8'(want.frame_ready), 8'(got.frame_ready));
      compare_field("command", want.command, got.command);
      compare_field("length", 8'(want.length), 8'(got.length));
      compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", 8'(want.payload_index), 8'(got.payload_index));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        $error("%0d results never arrived", expected_q.size());
        fail_count++;
      end
    endfunction
  endclass

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       push_i           = 1'b0;
  logic       operation_i      = OP_BYTE;
  logic [7:0] rx_data_i        = 8'h00;
  logic       pop_i            = 1'b0;
  logic       cfg_valid_i      = 1'b0;
  logic [7:0] cfg_start_byte_i = 8'h00;
  logic       full_o;
  logic       empty_o;
  logic       cfg_ready_o;
  logic [2:0] event_res_o;
  logic       frame_ready_o;
  logic [7:0] command_o;
  logic [5:0] length_o;
  logic       payload_valid_o;
  logic [7:0] payload_byte_o;
  logic [4:0] payload_index_o;
  logic       last_o;

  frame_scoreboard sb = new();

  logic [7:0]  start_value = START_BYTE_RST;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned pop_tick    = 0;
  int unsigned pop_mode    = 0;
  result_t     popped;

  sof_len_xor_frame_receiver dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .operation_i      (operation_i),
    .rx_data_i        (rx_data_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .event_res_o      (event_res_o),
    .frame_ready_o    (frame_ready_o),
    .command_o        (command_o),
    .length_o         (length_o),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_start_byte_i (cfg_start_byte_i)
  );

  always #2 clk_i = ~clk_i;

  // result side: check on pop, then pick the next pop value from the pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        popped.event_res     = event_res_o;
        popped.frame_ready   = frame_ready_o;
        popped.command       = command_o;
        popped.length        = length_o;
        popped.payload_valid = payload_valid_o;
        popped.payload_byte  = payload_byte_o;
        popped.payload_index = payload_index_o;
        popped.last          = last_o;
        sb.check_result(popped);
      end
      pop_tick <= pop_tick + 1;
      if (pop_tick % 48 == 0) pop_mode <= $urandom_range(0, 3);
      case (pop_mode)
        0: pop_i <= 1'b1;
        1: pop_i <= 1'($urandom_range(0, 1));
        2: pop_i <= (pop_tick % 6) < 2;
        default: pop_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // push one item, in bursts separated by random gaps
  task automatic send_item(input logic op, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    push_i      <= 1'b1;
    operation_i <= op;
    rx_data_i   <= data;
    do @(posedge clk_i); while (full_o);
    sb.note_item(op, data);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_take();
    send_item(OP_TAKE, 8'($urandom_range(0, 255)));
  endtask

  // start, command, length, then payload and checksum unless length is too big
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_byte,
                            input bit corrupt);
    logic [7:0] sum;
    logic [7:0] pb;
    send_item(OP_BYTE, start_value);
    send_item(OP_BYTE, cmd);
    send_item(OP_BYTE, len_byte);
    if (len_byte > PAYLOAD_CAP) return;
    sum = cmd ^ len_byte;
    for (int unsigned i = 0; i < len_byte; i++) begin
      pb  = 8'($urandom_range(0, 255));
      sum = sum ^ pb;
      send_item(OP_BYTE, pb);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_item(OP_BYTE, sum);
  endtask

  // stop pushing and let every owed result come out
  task automatic wait_idle();
    push_i     <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_byte(input logic [7:0] value);
    cfg_valid_i      <= 1'b1;
    cfg_start_byte_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_start_byte(value);
    start_value = value;
  endtask

  // mostly good frames with random content, mixed with broken ones and noise
  task automatic run_random_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n;
    stop_at = items_sent + count;
    // one full-size frame per phase to stream the whole store
    send_frame(8'($urandom_range(0, 255)), 8'(PAYLOAD_CAP), 1'b0);
    send_take();
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, PAYLOAD_CAP)
                                        : $urandom_range(0, 6);
        send_frame(8'($urandom_range(0, 255)), 8'(n), 1'b0);
        // sometimes bytes arrive while the frame is held
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        send_take();
      end else if (kind < 70) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)), 1'b1);
      end else if (kind < 77) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(PAYLOAD_CAP + 1, 255)),
                   1'b0);
      end else if (kind < 87) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, start_value);
          else send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
      end else if (kind < 93) begin
        send_take();
      end else begin
        // frame cut off after the command byte
        send_item(OP_BYTE, start_value);
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset start byte
    send_take();                          // take with no frame held
    send_item(OP_BYTE, 8'h00);            // noise while hunting
    send_frame(8'hFF, 8'd0, 1'b0);        // empty payload
    send_take();
    send_frame(8'h00, 8'd2, 1'b0);
    send_item(OP_BYTE, 8'hAA);            // ignored while held
    send_take();
    send_frame(8'h12, 8'(PAYLOAD_CAP + 1), 1'b0);  // length just over the store
    send_frame(8'h01, 8'd1, 1'b1);        // checksum mismatch
    // take in the middle of a frame must not disturb it
    send_item(OP_BYTE, start_value);
    send_item(OP_BYTE, 8'h7F);
    send_take();
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'hFE);
    send_take();
    wait_idle();

    write_start_byte(8'h00);
    run_random_phase(40);
    wait_idle();

    write_start_byte(8'hFF);
    run_random_phase(40);
    wait_idle();

    write_start_byte(8'($urandom_range(1, 254)));
    run_random_phase(40);
    wait_idle();

    sb.check_drained();
    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
